@@ rtl/sldve_pkg.sv @@
package sldve_pkg;

  // Default for the length field range of the stream
  localparam int unsigned LENGTH_BITS_DEF = 24;

  // Field widths fixed by the stream format
  localparam int unsigned VAL_W = 64;
  localparam int unsigned CFG_W = 24;
  localparam int unsigned LEN_W = 24;

  // Reset value of the capacity register
  localparam logic [CFG_W-1:0] BUFFER_BYTES_RST = 24'd4096;

  // Header word, sent as a nine byte code
  localparam logic [VAL_W-1:0] HDR_MAGIC = 64'hDEAD_BEEF_DEAD_BAAF;
  localparam logic [3:0]       LONG_LEN  = 4'd9;
  localparam logic [7:0]       LONG_PFX  = 8'h10;

  // Bytes kept back as margin
  localparam logic [CFG_W-1:0] MARGIN = 24'd9;

  // Item kinds
  localparam logic KIND_VALUE = 1'b0;
  localparam logic KIND_END   = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_CAP  = 2'd1;
  localparam logic [1:0] ST_SORT = 2'd2;

  typedef struct packed {
    logic             kind;
    logic [VAL_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic             is_last;
    logic [1:0]       status;
    logic [LEN_W-1:0] length;
  } out_t;

  // Closing result of a command
  typedef enum logic [1:0] {
    TL_NONE,
    TL_STOP,
    TL_ERR_CAP,
    TL_ERR_SORT
  } tail_t;

  // One command per item that gives results
  typedef struct packed {
    logic             hdr;
    logic [3:0]       clen;
    logic [VAL_W-1:0] delta;
    tail_t            tail;
    logic [LEN_W-1:0] length;
  } cmd_t;

  // Back end sequencer phases
  typedef enum logic [1:0] {
    PH_HDR,
    PH_CODE,
    PH_TAIL,
    PH_DONE
  } phase_t;

  // Byte i of an n byte code of d, most significant first
  function automatic logic [7:0] code_byte(logic [VAL_W-1:0] d, logic [3:0] n, logic [3:0] i);
    logic [3:0]       sh;
    logic [VAL_W-1:0] shifted;
    sh      = 4'(n - 4'd1 - i);
    shifted = d >> {sh[2:0], 3'b000};
    if (i == 4'd0) begin
      case (n)
        4'd1:    code_byte = {1'b1, d[6:0]};
        4'd2:    code_byte = {2'b01, d[13:8]};
        4'd3:    code_byte = {3'b001, d[20:16]};
        default: code_byte = LONG_PFX;
      endcase
    end else begin
      code_byte = shifted[7:0];
    end
  endfunction

  function automatic phase_t first_phase(cmd_t c);
    if (c.hdr)               first_phase = PH_HDR;
    else if (c.clen != 4'd0) first_phase = PH_CODE;
    else                     first_phase = PH_TAIL;
  endfunction

  function automatic phase_t phase_after(phase_t p, cmd_t c);
    phase_after = PH_DONE;
    unique case (p)
      PH_HDR: begin
        if (c.clen != 4'd0)       phase_after = PH_CODE;
        else if (c.tail != TL_NONE) phase_after = PH_TAIL;
      end
      PH_CODE: begin
        if (c.tail != TL_NONE) phase_after = PH_TAIL;
      end
      default: phase_after = PH_DONE;
    endcase
  endfunction

  function automatic logic [3:0] last_idx(phase_t p, cmd_t c);
    unique case (p)
      PH_HDR:  last_idx = 4'(LONG_LEN - 4'd1);
      PH_CODE: last_idx = 4'(c.clen - 4'd1);
      default: last_idx = 4'd0;
    endcase
  endfunction

endpackage

@@ rtl/sldve_front.sv @@
module sldve_front #(
  parameter int unsigned LENGTH_BITS = sldve_pkg::LENGTH_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  input  logic [sldve_pkg::CFG_W-1:0]       cfg_data,
  input  logic                              accept,
  input  sldve_pkg::in_t                    item,
  output logic                              push,
  output sldve_pkg::cmd_t                   cmd
);
  import sldve_pkg::*;

  // Byte count never reaches the clamped capacity
  localparam int unsigned CntW = (LENGTH_BITS < CFG_W) ? LENGTH_BITS : CFG_W;
  localparam logic [CFG_W-1:0] CapMax = CFG_W'((64'd1 << CntW) - 64'd1);

  logic [CFG_W-1:0] buffer_bytes;
  logic [VAL_W-1:0] previous_value, previous_value_next;
  logic             header_sent, header_sent_next;
  logic             dropping, dropping_next;
  logic [CntW-1:0]  byte_count, byte_count_next;

  logic [CFG_W-1:0] clamp;
  logic             cap_small, hdr_ovf;
  logic             first, borrow, d_zero, ovf;
  logic [VAL_W-1:0] d;
  logic [3:0]       clen;
  logic [CntW-1:0]  base, stop_cnt;
  logic [CFG_W:0]   bcn;

  // Capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_bytes <= BUFFER_BYTES_RST;
    end else if (cfg_valid) begin
      buffer_bytes <= cfg_data;
    end
  end

  // Capacity checks
  assign clamp     = (buffer_bytes > CapMax) ? CapMax : buffer_bytes;
  assign cap_small = clamp < MARGIN;
  assign hdr_ovf   = clamp < (MARGIN + MARGIN + CFG_W'(1));

  // Delta and code length
  assign first         = !header_sent;
  assign {borrow, d}   = {1'b0, item.value} - {1'b0, previous_value};
  assign d_zero        = (d == '0);
  always_comb begin
    if (d[63:7] == '0)       clen = 4'd1;
    else if (d[63:14] == '0) clen = 4'd2;
    else if (d[63:21] == '0) clen = 4'd3;
    else                     clen = LONG_LEN;
  end

  // Running byte count
  assign base     = first ? CntW'(MARGIN) : byte_count;
  assign bcn      = {1'b0, CFG_W'(base)} + (CFG_W+1)'(clen);
  assign ovf      = (bcn + (CFG_W+1)'(MARGIN)) >= {1'b0, clamp};
  assign stop_cnt = base + CntW'(1);

  // Classify the item and build its command
  always_comb begin
    cmd.hdr             = 1'b0;
    cmd.clen            = 4'd0;
    cmd.delta           = d;
    cmd.tail            = TL_NONE;
    cmd.length          = '0;
    push                = 1'b0;
    previous_value_next = previous_value;
    header_sent_next    = header_sent;
    dropping_next       = dropping;
    byte_count_next     = byte_count;
    if (item.kind == KIND_END) begin
      if (!dropping) begin
        push = 1'b1;
        if (first && cap_small) begin
          cmd.tail = TL_ERR_CAP;
        end else if (first && hdr_ovf) begin
          cmd.hdr  = 1'b1;
          cmd.tail = TL_ERR_CAP;
        end else begin
          cmd.hdr    = first;
          cmd.tail   = TL_STOP;
          cmd.length = LEN_W'(stop_cnt);
        end
      end
      previous_value_next = '0;
      header_sent_next    = 1'b0;
      dropping_next       = 1'b0;
      byte_count_next     = '0;
    end else if (!dropping) begin
      if (first && cap_small) begin
        push          = 1'b1;
        cmd.tail      = TL_ERR_CAP;
        dropping_next = 1'b1;
      end else if (first && hdr_ovf) begin
        push             = 1'b1;
        cmd.hdr          = 1'b1;
        cmd.tail         = TL_ERR_CAP;
        dropping_next    = 1'b1;
        header_sent_next = 1'b1;
      end else begin
        cmd.hdr          = first;
        header_sent_next = 1'b1;
        if (borrow) begin
          push          = 1'b1;
          cmd.tail      = TL_ERR_SORT;
          dropping_next = 1'b1;
        end else begin
          previous_value_next = item.value;
          // a repeated value leaves no trace
          if (!d_zero || first) begin
            push            = 1'b1;
            cmd.clen        = clen;
            byte_count_next = bcn[CntW-1:0];
            if (ovf) begin
              cmd.tail      = TL_ERR_CAP;
              dropping_next = 1'b1;
            end
          end
        end
      end
    end
    if (!accept) push = 1'b0;
  end

  // List state
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_value <= '0;
      header_sent    <= 1'b0;
      dropping       <= 1'b0;
      byte_count     <= '0;
    end else if (accept) begin
      previous_value <= previous_value_next;
      header_sent    <= header_sent_next;
      dropping       <= dropping_next;
      byte_count     <= byte_count_next;
    end
  end

  // List state is cleared by every end marker
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    accept && item.kind == KIND_END |=> !header_sent && !dropping && byte_count == '0)
    else $error("end marker did not clear list state");

  // Once the header is out, the count includes it
  a_count_hdr: assert property (@(posedge clk) disable iff (rst)
    header_sent && !dropping |-> byte_count >= CntW'(MARGIN))
    else $error("byte count below header length");

endmodule

@@ rtl/sldve_queue.sv @@
module sldve_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  sldve_pkg::cmd_t wr_cmd,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output sldve_pkg::cmd_t head
);
  import sldve_pkg::*;

  cmd_t       mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= 2'(count + {1'b0, push} - {1'b0, pop});
    end
  end

  a_fill: assert property (@(posedge clk) disable iff (rst)
    !(push && full) && !(pop && empty) && count <= 2'd2)
    else $error("command queue over or underflow");

endmodule

@@ rtl/sldve_back.sv @@
module sldve_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            empty,
  input  sldve_pkg::cmd_t head,
  output logic            pop,
  output logic            result_valid,
  input  logic            result_ready,
  output sldve_pkg::out_t result
);
  import sldve_pkg::*;

  phase_t     phase, phase_next, cur_phase, nxt_phase;
  logic       started, started_next;
  logic [3:0] idx, idx_next;
  logic       can_emit, at_last;
  out_t       res_d;

  // A new result is formed when the output slot is free or being taken
  assign can_emit  = !empty && (!result_valid || result_ready);
  assign cur_phase = started ? phase : first_phase(head);
  assign at_last   = (idx == last_idx(cur_phase, head));
  assign nxt_phase = phase_after(cur_phase, head);

  // Next state
  always_comb begin
    phase_next   = phase;
    started_next = started;
    idx_next     = idx;
    if (can_emit) begin
      if (!at_last) begin
        phase_next   = cur_phase;
        started_next = 1'b1;
        idx_next     = idx + 4'd1;
      end else if (nxt_phase == PH_DONE) begin
        started_next = 1'b0;
        idx_next     = 4'd0;
      end else begin
        phase_next   = nxt_phase;
        started_next = 1'b1;
        idx_next     = 4'd0;
      end
    end
  end

  // Outputs of the sequencer
  always_comb begin
    res_d.out_byte = 8'h00;
    res_d.is_last  = 1'b0;
    res_d.status   = ST_OK;
    res_d.length   = '0;
    unique case (cur_phase)
      PH_HDR:  res_d.out_byte = code_byte(HDR_MAGIC, LONG_LEN, idx);
      PH_CODE: res_d.out_byte = code_byte(head.delta, head.clen, idx);
      PH_TAIL: begin
        res_d.is_last = 1'b1;
        unique case (head.tail)
          TL_STOP: begin
            res_d.status = ST_OK;
            res_d.length = head.length;
          end
          TL_ERR_CAP:  res_d.status = ST_CAP;
          TL_ERR_SORT: res_d.status = ST_SORT;
          default:     res_d.status = ST_OK;
        endcase
      end
      default: res_d.out_byte = 8'h00;
    endcase
    pop = can_emit && at_last && (nxt_phase == PH_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_HDR;
      started <= 1'b0;
      idx     <= 4'd0;
    end else begin
      phase   <= phase_next;
      started <= started_next;
      idx     <= idx_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (can_emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (can_emit) begin
      result <= res_d;
    end
  end

  // A command part way through stays at the queue head
  a_head_held: assert property (@(posedge clk) disable iff (rst)
    started |-> !empty)
    else $error("command left the queue mid sequence");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    idx <= 4'(LONG_LEN - 4'd1))
    else $error("byte index out of range");

  // Errors always close the list with a zero byte
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != ST_OK |-> result.is_last && result.out_byte == 8'h00)
    else $error("error result not closing");

endmodule

@@ rtl/sorted_list_delta_varint_encoder_core.sv @@
// Delta varint encoder for ascending lists of 64-bit values.
// Items arrive on item_valid/item_ready: kind 0 carries a list value, kind 1
// closes the list. Result items leave on result_valid/result_ready, one
// stream byte per item, with a closing stop or error item flagged by is_last.
// cfg_valid/cfg_data writes the output capacity in bytes (cfg_ready is
// always high); write it only while the block is idle.
// The front end classifies one item per cycle while the queue has room and
// writes a command into a two-entry queue; the back end sequencer takes the
// command at the queue head and registers one result per cycle into the output
// register while the receiver takes them. An item gives one result for a short
// delta and up to nineteen for a header, long code and error; an item giving
// no result queues no command.
// When the receiver stalls, the output register holds its item, the queue
// fills and item_ready drops once both queue entries are taken.
// Reset clears the list state and the queue and sets the capacity to 4096.
module sorted_list_delta_varint_encoder_core #(
  parameter int unsigned LENGTH_BITS = sldve_pkg::LENGTH_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [sldve_pkg::CFG_W-1:0] cfg_data,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  sldve_pkg::in_t              item,
  output logic                        result_valid,
  input  logic                        result_ready,
  output sldve_pkg::out_t             result
);
  import sldve_pkg::*;

  logic accept, push, full, pop, empty;
  cmd_t wr_cmd, head;

  assign cfg_ready  = 1'b1;
  assign item_ready = !full;
  assign accept     = item_valid && item_ready;

  sldve_front #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .item      (item),
    .push      (push),
    .cmd       (wr_cmd)
  );

  sldve_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_cmd (wr_cmd),
    .full   (full),
    .pop    (pop),
    .empty  (empty),
    .head   (head)
  );

  sldve_back u_back (
    .clk          (clk),
    .rst          (rst),
    .empty        (empty),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

@@ dv/sorted_list_delta_varint_encoder_core_tb.sv @@
module sorted_list_delta_varint_encoder_core_tb;
  import sldve_pkg::*;

  // Receiver hold-off length, idle-cycle watchdog and settle time after the last result
  localparam int OUT_HOLD_CYCLES = 300;
  localparam int STALL_LIMIT     = 3000;
  localparam int SETTLE_CYCLES   = 40;

  logic             clk          = 1'b0;
  logic             rst          = 1'b1;
  logic             cfg_valid    = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data     = '0;
  logic             item_valid   = 1'b0;
  logic             item_ready;
  in_t              item         = '0;
  logic             result_valid;
  logic             result_ready = 1'b0;
  out_t             result;

  sorted_list_delta_varint_encoder_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #5 clk = ~clk;

  // Encoder state as predicted, plus the capacity register
  logic [CFG_W-1:0] cap_bytes = BUFFER_BYTES_RST;
  logic [VAL_W-1:0] prev_val  = '0;
  logic             hdr_sent  = 1'b0;
  logic             dropping  = 1'b0;
  int unsigned      byte_cnt  = 0;

  // Stream bytes still to come, oldest first
  out_t stream_q[$];
  out_t want;

  int err_cnt     = 0;
  int items_sent  = 0;
  int quiet_cycles = 0;
  bit tx_burst    = 1'b0;
  bit rx_burst    = 1'b0;
  bit hold_req    = 1'b0;

  function automatic void push_byte(logic [7:0] b, logic last, logic [1:0] st,
                                    logic [LEN_W-1:0] len);
    out_t r;
    r.out_byte = b;
    r.is_last  = last;
    r.status   = st;
    r.length   = len;
    stream_q.push_back(r);
  endfunction

  // Usable capacity: register less the overcommit margin, may go negative
  function automatic longint usable_cap();
    return longint'(cap_bytes) - longint'(MARGIN);
  endfunction

  // Big-endian varint of one delta, prefix bit marks the size
  function automatic void emit_delta(logic [VAL_W-1:0] d);
    if (d < 64'd128) begin
      push_byte({1'b1, d[6:0]}, 1'b0, ST_OK, '0);
      byte_cnt += 1;
    end else if (d < 64'd16384) begin
      push_byte({2'b01, d[13:8]}, 1'b0, ST_OK, '0);
      push_byte(d[7:0], 1'b0, ST_OK, '0);
      byte_cnt += 2;
    end else if (d < 64'd2097152) begin
      push_byte({3'b001, d[20:16]}, 1'b0, ST_OK, '0);
      push_byte(d[15:8], 1'b0, ST_OK, '0);
      push_byte(d[7:0], 1'b0, ST_OK, '0);
      byte_cnt += 3;
    end else begin
      push_byte(LONG_PFX, 1'b0, ST_OK, '0);
      for (int k = 7; k >= 0; k--)
        push_byte(d[k*8 +: 8], 1'b0, ST_OK, '0);
      byte_cnt += 9;
    end
  endfunction

  function automatic bit overflow_check();
    if (longint'(byte_cnt) >= usable_cap()) begin
      push_byte(8'h00, 1'b1, ST_CAP, '0);
      dropping = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Header ahead of the first item of a list; returns 1 if the list failed
  function automatic bit open_list();
    if (usable_cap() < 0) begin
      push_byte(8'h00, 1'b1, ST_CAP, '0);
      dropping = 1'b1;
      return 1'b1;
    end
    hdr_sent = 1'b1;
    byte_cnt = 0;
    emit_delta(HDR_MAGIC);
    return overflow_check();
  endfunction

  function automatic void clear_list();
    prev_val = '0;
    hdr_sent = 1'b0;
    dropping = 1'b0;
    byte_cnt = 0;
  endfunction

  // Stream bytes caused by one accepted item
  function automatic void predict_encoding(in_t it);
    logic             first;
    logic             bad;
    logic [VAL_W-1:0] d;
    if (it.kind == KIND_END) begin
      if (!dropping) begin
        bad = hdr_sent ? 1'b0 : open_list();
        if (!bad)
          push_byte(8'h00, 1'b1, ST_OK, LEN_W'(byte_cnt + 1));
      end
      clear_list();
      return;
    end
    if (dropping)
      return;
    first = !hdr_sent;
    if (first && open_list())
      return;
    if (it.value < prev_val) begin
      push_byte(8'h00, 1'b1, ST_SORT, '0);
      dropping = 1'b1;
      return;
    end
    d        = it.value - prev_val;
    prev_val = it.value;
    // repeats after the first value are skipped
    if (d != '0 || first) begin
      emit_delta(d);
      void'(overflow_check());
    end
  endfunction

  function automatic logic [VAL_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Next value of an ascending list, delta drawn across all code sizes
  function automatic logic [VAL_W-1:0] next_value(logic [VAL_W-1:0] cur);
    logic [VAL_W-1:0] d;
    logic [VAL_W-1:0] room;
    int               pick;
    room = ~cur;
    pick = $urandom_range(0, 99);
    if (pick < 12)      d = '0;
    else if (pick < 45) d = 64'($urandom_range(1, 127));
    else if (pick < 65) d = 64'($urandom_range(128, 16383));
    else if (pick < 78) d = 64'($urandom_range(16384, 2097151));
    else if (pick < 84) d = $urandom_range(0, 1) ? 64'd2097151 : 64'd2097152;
    else                d = rand64() >> $urandom_range(0, 40);
    if (d > room)
      d = d % (room + 64'd1);
    return cur + d;
  endfunction

  // Offer one item after a random gap, predict on acceptance
  task automatic send_item(logic kind, logic [VAL_W-1:0] value);
    int gap;
    gap = (tx_burst || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= {kind, value};
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    predict_encoding(item);
    items_sent++;
  endtask

  // n values then the end marker; now and then a value drops below the last
  task automatic send_list(int n);
    logic [VAL_W-1:0] cur;
    cur = ($urandom_range(0, 9) == 0) ? rand64() : 64'($urandom_range(0, 1000));
    for (int i = 0; i < n; i++) begin
      if (i > 0 && cur != '0 && $urandom_range(0, 29) == 0)
        cur = cur - 64'd1 - (rand64() % cur);
      else if (i > 0)
        cur = next_value(cur);
      send_item(KIND_VALUE, cur);
    end
    send_item(KIND_END, rand64());
  endtask

  // Wait for every predicted byte, then let queued silent items retire
  task automatic drain();
    item_valid <= 1'b0;
    while (stream_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_capacity(logic [CFG_W-1:0] bytes);
    cfg_valid <= 1'b1;
    cfg_data  <= bytes;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cap_bytes = bytes;
  endtask

  // Reset capacity: empty list, code size boundaries, repeats, unsorted values
  task automatic test_directed();
    send_item(KIND_END, '1);
    send_item(KIND_VALUE, 64'd0);
    send_item(KIND_VALUE, 64'd0);
    send_item(KIND_VALUE, 64'd127);
    send_item(KIND_VALUE, 64'd255);
    send_item(KIND_VALUE, 64'd16638);
    send_item(KIND_VALUE, 64'd33022);
    send_item(KIND_VALUE, 64'd2130173);
    send_item(KIND_VALUE, 64'd4227325);
    send_item(KIND_VALUE, '1);
    send_item(KIND_VALUE, '1);
    send_item(KIND_END, 64'd0);
    // drop after unsorted value, end marker while dropping
    send_item(KIND_VALUE, 64'd1000);
    send_item(KIND_VALUE, 64'd5);
    send_item(KIND_VALUE, 64'd7);
    send_item(KIND_END, 64'd0);
    // top of range as the first value
    send_item(KIND_VALUE, '1);
    send_item(KIND_END, 64'h5555_5555_5555_5555);
    send_item(KIND_VALUE, 64'h8000_0000_0000_0000);
    send_item(KIND_END, 64'd0);
    drain();
  endtask

  // Capacity below the header, header filling it, overflow after a code
  task automatic test_small_capacity();
    logic [CFG_W-1:0] caps [6] = '{24'd0, 24'd8, 24'd9, 24'd18, 24'd19, 24'd20};
    foreach (caps[i]) begin
      drain();
      set_capacity(caps[i]);
      send_item(KIND_END, rand64());
      send_item(KIND_VALUE, 64'd3);
      send_item(KIND_VALUE, 64'd4);
      send_item(KIND_VALUE, 64'd200);
      send_item(KIND_END, rand64());
    end
    drain();
  endtask

  // Random lists over several capacities, one phase without any idling
  task automatic test_random_lists();
    logic [CFG_W-1:0] c;
    int               quota;
    for (int ph = 0; ph < 5; ph++) begin
      drain();
      case (ph)
        0:       c = '1;
        1:       c = CFG_W'($urandom_range(19, 80));
        2:       c = BUFFER_BYTES_RST;
        3:       c = CFG_W'($urandom_range(80, 400));
        default: c = CFG_W'($urandom_range(0, 24'hFF_FFFF));
      endcase
      set_capacity(c);
      tx_burst = (ph == 2);
      rx_burst = (ph == 2);
      quota = items_sent + 50;
      while (items_sent < quota) begin
        if ($urandom_range(0, 19) == 0)
          send_item(1'($urandom_range(0, 1)), rand64());
        else
          send_list($urandom_range(0, 10));
      end
      tx_burst = 1'b0;
      rx_burst = 1'b0;
    end
    drain();
  endtask

  // Receiver holds off while items keep coming, so the input stalls
  task automatic test_output_stall();
    drain();
    set_capacity(BUFFER_BYTES_RST);
    tx_burst = 1'b1;
    hold_req = 1'b1;
    send_list(12);
    send_list(12);
    tx_burst = 1'b0;
    drain();
  endtask

  // Result side: random ready gaps, long hold when asked
  initial begin : receiver
    int w;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        result_ready <= 1'b0;
        repeat (OUT_HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      w = (rx_burst || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      if (w > 0) begin
        result_ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (!result_valid && !hold_req) @(posedge clk);
    end
  end

  // Compare each accepted result with the oldest predicted byte
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (stream_q.size() == 0) begin
        $error("result with nothing expected: out_byte %0h is_last %0b status %0d",
               result.out_byte, result.is_last, result.status);
        err_cnt++;
      end else begin
        want = stream_q.pop_front();
        if (result.out_byte !== want.out_byte) begin
          $error("out_byte: expected %0h, got %0h", want.out_byte, result.out_byte);
          err_cnt++;
        end
        if (result.is_last !== want.is_last) begin
          $error("is_last: expected %0b, got %0b", want.is_last, result.is_last);
          err_cnt++;
        end
        if (result.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, result.status);
          err_cnt++;
        end
        if (result.length !== want.length) begin
          $error("length: expected %0d, got %0d", want.length, result.length);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((item_valid && item_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_small_capacity();
    test_random_lists();
    test_output_stall();
    if (err_cnt == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ sorted_list_delta_varint_encoder_core.f @@
rtl/sldve_pkg.sv
rtl/sldve_front.sv
rtl/sldve_queue.sv
rtl/sldve_back.sv
rtl/sorted_list_delta_varint_encoder_core.sv
dv/sorted_list_delta_varint_encoder_core_tb.sv
